[design/dq_pkg.sv]
package dq_pkg;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned COUNT_W     = $clog2(CAPACITY + 1);

  localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_HEAD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_TAIL  = 3'd3;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  // Control broadcast to every cell of the chain for one cycle.
  typedef struct packed {
    logic   shift_in;
    logic   shift_out;
    logic   put_tail;
    logic   drop_tail;
    value_t value;
  } cell_ctrl_t;

endpackage

[design/dq_cell.sv]
module dq_cell
  import dq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       left_valid_i,
  input  value_t     left_data_i,
  input  logic       right_valid_i,
  input  value_t     right_data_i,
  output logic       valid_o,
  output value_t     data_o
);

  logic   valid_q, valid_d;
  value_t data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctrl_i.shift_in) begin
      valid_d = left_valid_i;
      data_d  = left_data_i;
    end else if (ctrl_i.shift_out) begin
      valid_d = right_valid_i;
      data_d  = right_data_i;
    end else if (ctrl_i.put_tail) begin
      if (!valid_q && left_valid_i) begin
        valid_d = 1'b1;
        data_d  = ctrl_i.value;
      end
    end else if (ctrl_i.drop_tail) begin
      valid_d = valid_q & right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[design/double_ended_queue.sv]
// A result is held in a pending register when its word is accepted and is
// loaded into the output register once that register is free.
// No new word is taken while one is pending. The chain updates on accept,
// and the head, tail and count are gathered from it on the pending load.
// Reset clears every cell's valid bit and the entry count, leaving the queue
// empty; cell data is not reset.
module double_ended_queue
  import dq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CMD_W-1:0]       cmd_i,
  input  logic [VALUE_WIDTH-1:0] push_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   op_ok_o,
  output logic [VALUE_WIDTH-1:0] popped_value_o,
  output logic [VALUE_WIDTH-1:0] front_value_o,
  output logic [VALUE_WIDTH-1:0] back_value_o,
  output logic                   is_empty_o,
  output logic                   is_full_o,
  output logic [COUNT_W-1:0]     entry_count_o
);

  cell_ctrl_t ctrl;
  logic       valid_w [CAPACITY];
  value_t     data_w  [CAPACITY];
  logic       cell_valid [CAPACITY];
  value_t     cell_data  [CAPACITY];
  logic       is_last    [CAPACITY];
  value_t     back_now;

  logic [COUNT_W-1:0] count_q, count_d;
  logic               pend_q, pend_d;
  logic               pend_ok_q, ok_d;
  value_t             pend_popped_q, popped_d;
  logic               accept, load;
  logic               full, empty;

  logic               out_valid_q;
  logic               op_ok_q;
  value_t             popped_q, front_q, back_q;
  logic               empty_q, full_q;
  logic [COUNT_W-1:0] out_count_q;

  // The left end of the chain sees an always valid neighbor carrying the
  // pushed value, and the right end sees an empty one.
  assign valid_w[0] = 1'b1;
  assign data_w[0]  = push_value_i;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   right_valid;
    value_t right_data;

    if (i == CAPACITY - 1) begin : g_end
      assign right_valid = 1'b0;
      assign right_data  = '0;
    end else begin : g_mid
      assign right_valid  = cell_valid[i+1];
      assign right_data   = cell_data[i+1];
      assign valid_w[i+1] = cell_valid[i];
      assign data_w[i+1]  = cell_data[i];
    end

    dq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .left_valid_i (valid_w[i]),
      .left_data_i  (data_w[i]),
      .right_valid_i(right_valid),
      .right_data_i (right_data),
      .valid_o      (cell_valid[i]),
      .data_o       (cell_data[i])
    );

    assign is_last[i] = cell_valid[i] & ~right_valid;
  end

  always_comb begin
    back_now = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_now = back_now | (is_last[i] ? cell_data[i] : '0);
    end
  end

  assign full       = (count_q == COUNT_W'(CAPACITY));
  assign empty      = (count_q == '0);
  assign in_ready_o = ~pend_q;
  assign accept     = in_valid_i & in_ready_o;
  assign load       = pend_q & (~out_valid_q | out_ready_i);

  always_comb begin
    ctrl       = '0;
    ctrl.value = push_value_i;
    ok_d       = 1'b1;
    popped_d   = '0;
    count_d    = count_q;
    if (accept) begin
      unique case (cmd_i)
        CMD_PUSH_HEAD: begin
          if (full) begin
            ok_d = 1'b0;
          end else begin
            ctrl.shift_in = 1'b1;
            count_d       = count_q + 1'b1;
          end
        end
        CMD_PUSH_TAIL: begin
          if (full) begin
            ok_d = 1'b0;
          end else begin
            ctrl.put_tail = 1'b1;
            count_d       = count_q + 1'b1;
          end
        end
        CMD_POP_HEAD: begin
          if (empty) begin
            ok_d = 1'b0;
          end else begin
            ctrl.shift_out = 1'b1;
            popped_d       = cell_data[0];
            count_d        = count_q - 1'b1;
          end
        end
        CMD_POP_TAIL: begin
          if (empty) begin
            ok_d = 1'b0;
          end else begin
            ctrl.drop_tail = 1'b1;
            popped_d       = back_now;
            count_d        = count_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = 1'b1;
    end else if (load) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= pend_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_ok_q     <= ok_d;
      pend_popped_q <= popped_d;
    end
    if (load) begin
      op_ok_q     <= pend_ok_q;
      popped_q    <= pend_popped_q;
      front_q     <= cell_valid[0] ? cell_data[0] : '0;
      back_q      <= back_now;
      empty_q     <= empty;
      full_q      <= full;
      out_count_q <= count_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign op_ok_o        = op_ok_q;
  assign popped_value_o = popped_q;
  assign front_value_o  = front_q;
  assign back_value_o   = back_q;
  assign is_empty_o     = empty_q;
  assign is_full_o      = full_q;
  assign entry_count_o  = out_count_q;

endmodule

[tb/sv/double_ended_queue_tb.sv]
module double_ended_queue_tb;
  import dq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_NO_OP        = 3'd4;
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;
  localparam int unsigned      HOLD_CYCLES      = 300;
  localparam int unsigned      STALL_LIMIT      = 2000;
  localparam int unsigned      MAX_REPORTS      = 10;

  typedef struct packed {
    logic               op_ok;
    value_t             popped_value;
    value_t             front_value;
    value_t             back_value;
    logic               is_empty;
    logic               is_full;
    logic [COUNT_W-1:0] entry_count;
  } deque_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [CMD_W-1:0]   cmd_i;
  value_t             push_value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               op_ok_o;
  value_t             popped_value_o;
  value_t             front_value_o;
  value_t             back_value_o;
  logic               is_empty_o;
  logic               is_full_o;
  logic [COUNT_W-1:0] entry_count_o;

  value_t        held_values[$];
  deque_result_t pending_results[$];
  int unsigned   error_count;
  int unsigned   stall_cycles;
  bit            sender_idles;
  bit            receiver_idles;
  bit            hold_receiver;

  double_ended_queue DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .op_ok_o        (op_ok_o),
    .popped_value_o (popped_value_o),
    .front_value_o  (front_value_o),
    .back_value_o   (back_value_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o),
    .entry_count_o  (entry_count_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic deque_result_t apply_command(logic [CMD_W-1:0] cmd, value_t value);
    deque_result_t r;
    r = '0;
    r.op_ok = 1'b1;
    case (cmd)
      CMD_PUSH_HEAD: begin
        if (held_values.size() < CAPACITY) held_values.push_front(value);
        else r.op_ok = 1'b0;
      end
      CMD_PUSH_TAIL: begin
        if (held_values.size() < CAPACITY) held_values.push_back(value);
        else r.op_ok = 1'b0;
      end
      CMD_POP_HEAD: begin
        if (held_values.size() != 0) r.popped_value = held_values.pop_front();
        else r.op_ok = 1'b0;
      end
      CMD_POP_TAIL: begin
        if (held_values.size() != 0) r.popped_value = held_values.pop_back();
        else r.op_ok = 1'b0;
      end
      default: begin
      end
    endcase
    if (held_values.size() != 0) begin
      r.front_value = held_values[0];
      r.back_value  = held_values[$];
    end
    r.is_empty    = (held_values.size() == 0);
    r.is_full     = (held_values.size() == CAPACITY);
    r.entry_count = COUNT_W'(held_values.size());
    return r;
  endfunction

  function automatic value_t random_value();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return value_t'({$urandom(), $urandom()});
  endfunction

  task automatic send_word(logic [CMD_W-1:0] cmd, value_t value);
    while (sender_idles && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    push_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_command(cmd, value));
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: result word with nothing expected", $realtime);
        end
      end else begin
        deque_result_t want;
        want = pending_results.pop_front();
        check_field("op_ok", 64'(want.op_ok), 64'(op_ok_o));
        check_field("popped_value", 64'(want.popped_value), 64'(popped_value_o));
        check_field("front_value", 64'(want.front_value), 64'(front_value_o));
        check_field("back_value", 64'(want.back_value), 64'(back_value_o));
        check_field("is_empty", 64'(want.is_empty), 64'(is_empty_o));
        check_field("is_full", 64'(want.is_full), 64'(is_full_o));
        check_field("entry_count", 64'(want.entry_count), 64'(entry_count_o));
      end
    end
  end

  initial begin : receiver
    int unsigned hold_left;
    bit          hold_armed;
    hold_left   = 0;
    hold_armed  = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_receiver) begin
        hold_armed = 1'b0;
      end else if (!hold_armed && hold_left == 0) begin
        hold_left  = HOLD_CYCLES;
        hold_armed = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(receiver_idles && $urandom_range(99) < 35);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic test_empty_queue();
    send_word(CMD_POP_HEAD, random_value());
    send_word(CMD_POP_TAIL, random_value());
    send_word(CMD_NO_OP, random_value());
    send_word(CMD_UNUSED_FIRST, random_value());
    send_word(CMD_UNUSED_LAST, '1);
    wait_for_results();
  endtask

  task automatic test_fill_to_capacity();
    send_word(CMD_PUSH_TAIL, '0);
    send_word(CMD_PUSH_HEAD, '1);
    for (int unsigned n = 2; n < CAPACITY; n++) begin
      send_word((n % 2) ? CMD_PUSH_HEAD : CMD_PUSH_TAIL, random_value());
    end
    send_word(CMD_PUSH_HEAD, random_value());
    send_word(CMD_PUSH_TAIL, random_value());
    wait_for_results();
  endtask

  task automatic test_random_traffic(int unsigned count);
    int unsigned      push_weight;
    logic [CMD_W-1:0] cmd;
    push_weight = 70;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 60 == 59) push_weight = 100 - push_weight;
      if ($urandom_range(99) < 6) begin
        cmd = CMD_W'($urandom_range(CMD_NO_OP, CMD_UNUSED_LAST));
      end else if ($urandom_range(99) < push_weight) begin
        cmd = $urandom_range(1) ? CMD_PUSH_TAIL : CMD_PUSH_HEAD;
      end else begin
        cmd = $urandom_range(1) ? CMD_POP_TAIL : CMD_POP_HEAD;
      end
      send_word(cmd, random_value());
    end
    wait_for_results();
  endtask

  task automatic test_output_stall();
    hold_receiver = 1'b1;
    test_random_traffic(40);
    hold_receiver = 1'b0;
  endtask

  task automatic test_back_to_back();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    test_random_traffic(100);
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  initial begin
    error_count    = 0;
    stall_cycles   = 0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    hold_receiver  = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    cmd_i          = CMD_NO_OP;
    push_value_i   = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_fill_to_capacity();
    test_random_traffic(320);
    test_output_stall();
    test_back_to_back();
    test_random_traffic(320);

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
